// ----- src/tllc_pkg.sv -----
// shared types and constants for the two-level lru cache tag model
package tllc_pkg;

    localparam int LOG2_MAX_ROWS_DEF = 8;
    localparam int MAX_WAYS_DEF      = 16;
    localparam int ADDR_BITS_DEF     = 13;

    localparam int TAG_W  = 13;
    localparam int RANK_W = 4;
    localparam int PC_W   = 16;
    localparam int ROW_W  = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 4;

    localparam logic [CFG_IDX_W-1:0] REG_L1_SIZE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_L1_ASSOC = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_L1_BLOCK = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_L2_EN    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_L2_SIZE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_L2_ASSOC = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_L2_BLOCK = 3'd6;

    localparam logic [1:0] EV_STORE = 2'd0;
    localparam logic [1:0] EV_HIT   = 2'd1;
    localparam logic [1:0] EV_MISS  = 2'd2;

    // geometry of one level
    typedef struct packed {
        logic [3:0] log2_size;
        logic [2:0] log2_assoc;
        logic [2:0] log2_block;
    } lvl_cfg_t;

    // one classified request as it sits in the queue
    typedef struct packed {
        logic            store;
        logic [15:0]     addr;
        logic [PC_W-1:0] pc;
        logic            l2_en;
    } job_t;

endpackage

// ----- src/tllc_front.sv -----
// request intake: config registers and a small queue of classified requests
module tllc_front #(
    parameter int ADDR_BITS = tllc_pkg::ADDR_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          valid,
    output logic                          ready,
    input  logic                          req_type,
    input  logic [ADDR_BITS-1:0]          addr,
    input  logic [tllc_pkg::PC_W-1:0]     pc,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tllc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tllc_pkg::CFG_DATA_W-1:0] cfg_data,
    output tllc_pkg::lvl_cfg_t            l1_cfg,
    output tllc_pkg::lvl_cfg_t            l2_cfg,
    output logic                          job_valid,
    input  logic                          job_ready,
    output tllc_pkg::job_t                job
);
    import tllc_pkg::*;

    localparam int DEPTH = 2;

    lvl_cfg_t l1_reg, l2_reg;
    logic     l2en_reg;
    job_t     q_reg [DEPTH];
    logic     rd_ptr_reg, wr_ptr_reg;
    logic [1:0] cnt_reg;
    logic     push, pop;
    job_t     in_job;

    assign cfg_ready = 1'b1;
    assign l1_cfg = l1_reg;
    assign l2_cfg = l2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            l1_reg   <= '{4'd8, 3'd0, 3'd0};
            l2_reg   <= '{4'd10, 3'd0, 3'd0};
            l2en_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_L1_SIZE:  l1_reg.log2_size  <= cfg_data;
                REG_L1_ASSOC: l1_reg.log2_assoc <= cfg_data[2:0];
                REG_L1_BLOCK: l1_reg.log2_block <= cfg_data[2:0];
                REG_L2_EN:    l2en_reg          <= cfg_data[0];
                REG_L2_SIZE:  l2_reg.log2_size  <= cfg_data;
                REG_L2_ASSOC: l2_reg.log2_assoc <= cfg_data[2:0];
                REG_L2_BLOCK: l2_reg.log2_block <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        in_job = '0;
        in_job.store = req_type;
        in_job.addr  = 16'(addr);
        in_job.pc    = pc;
        in_job.l2_en = l2en_reg;
    end

    assign ready     = (cnt_reg != 2'(DEPTH));
    assign push      = valid && ready;
    assign job_valid = (cnt_reg != 2'd0);
    assign pop       = job_valid && job_ready;
    assign job       = q_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_ptr_reg] <= in_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

// ----- src/tllc_level.sv -----
// one cache level: row memory of tags, valid bits and lru ranks with a clearing pass
module tllc_level #(
    parameter int LOG2_MAX_ROWS = tllc_pkg::LOG2_MAX_ROWS_DEF,
    parameter int MAX_WAYS      = tllc_pkg::MAX_WAYS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    output logic                       busy,
    input  tllc_pkg::lvl_cfg_t         cfg,
    input  logic                       start,
    input  logic [15:0]                addr,
    output logic                       done,
    output logic                       hit,
    output logic [tllc_pkg::ROW_W-1:0] row_out
);
    import tllc_pkg::*;

    localparam int NROWS = 1 << LOG2_MAX_ROWS;
    localparam int RI_W  = (LOG2_MAX_ROWS > 0) ? LOG2_MAX_ROWS : 1;
    localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int SLOT_W = TAG_W + RANK_W + 1;
    localparam int LINE_W = SLOT_W * MAX_WAYS;

    localparam logic [1:0] S_CLR  = 2'd0;
    localparam logic [1:0] S_IDLE = 2'd1;
    localparam logic [1:0] S_RD   = 2'd2;

    logic [LINE_W-1:0] mem [NROWS];
    logic [LINE_W-1:0] rd_line_reg, wr_line;
    logic [1:0]        state_reg;
    logic [RI_W-1:0]   clr_reg, row_reg, wr_row;
    logic [TAG_W-1:0]  tag_reg;
    logic              we;

    // geometry from config
    logic signed [5:0] rb_s;
    logic [3:0]        rbits;
    logic [4:0]        ways;
    logic [15:0]       block, row_full, tag_full;

    always_comb
    begin
        rb_s = $signed({2'b0, cfg.log2_size}) - $signed({3'b0, cfg.log2_assoc})
             - $signed({3'b0, cfg.log2_block});
        if (rb_s < 0)
            rbits = 4'd0;
        else if (rb_s > 6'(LOG2_MAX_ROWS))
            rbits = 4'(LOG2_MAX_ROWS);
        else
            rbits = rb_s[3:0];
        if (cfg.log2_assoc >= 3'($clog2(MAX_WAYS) + 0) && (1 << cfg.log2_assoc) >= MAX_WAYS)
            ways = 5'(MAX_WAYS);
        else
            ways = 5'(1 << cfg.log2_assoc);
        block    = addr >> cfg.log2_block;
        row_full = block & ((16'd1 << rbits) - 16'd1);
        tag_full = block >> rbits;
    end

    // slot decode and update
    logic [TAG_W-1:0]  s_tag  [MAX_WAYS];
    logic [RANK_W-1:0] s_rank [MAX_WAYS];
    logic              s_val  [MAX_WAYS];
    logic              use_w  [MAX_WAYS];
    logic              h_any, f_any;
    logic [WAY_W-1:0]  h_w, f_w, m_w, w_sel;
    logic [RANK_W-1:0] m_r, r_sel;

    always_comb
    begin
        h_any = 1'b0; f_any = 1'b0;
        h_w = '0; f_w = '0; m_w = '0; m_r = '0;
        for (int v = 0; v < MAX_WAYS; v++)
        begin
            s_val[v]  = rd_line_reg[v*SLOT_W];
            s_rank[v] = rd_line_reg[v*SLOT_W+1 +: RANK_W];
            s_tag[v]  = rd_line_reg[v*SLOT_W+1+RANK_W +: TAG_W];
            use_w[v]  = (5'(v) < ways);
        end
        for (int v = MAX_WAYS-1; v >= 0; v--)
        begin
            if (use_w[v] && s_val[v] && s_tag[v] == tag_reg)
            begin
                h_any = 1'b1; h_w = WAY_W'(v);
            end
            if (use_w[v] && !s_val[v])
            begin
                f_any = 1'b1; f_w = WAY_W'(v);
            end
        end
        for (int v = 0; v < MAX_WAYS; v++)
        begin
            if (use_w[v] && s_rank[v] > m_r)
            begin
                m_r = s_rank[v]; m_w = WAY_W'(v);
            end
        end
        if (h_any)
        begin
            w_sel = h_w; r_sel = s_rank[h_w];
        end
        else if (f_any)
        begin
            w_sel = f_w; r_sel = 4'd15;
        end
        else
        begin
            w_sel = m_w; r_sel = m_r;
        end
        wr_line = rd_line_reg;
        for (int v = 0; v < MAX_WAYS; v++)
        begin
            if (use_w[v] && WAY_W'(v) != w_sel && s_val[v] && s_rank[v] < r_sel)
                wr_line[v*SLOT_W+1 +: RANK_W] = s_rank[v] + 4'd1;
        end
        wr_line[32'(w_sel)*SLOT_W +: SLOT_W] = {tag_reg, 4'd0, 1'b1};
    end

    assign we     = (state_reg == S_CLR) || (state_reg == S_RD);
    assign wr_row = (state_reg == S_CLR) ? clr_reg : row_reg;
    assign busy   = (state_reg == S_CLR);
    assign done   = (state_reg == S_RD);
    assign hit    = h_any;
    assign row_out = ROW_W'(row_reg);

    always_ff @(posedge clk)
    begin
        if (we)
            mem[wr_row] <= (state_reg == S_CLR) ? '0 : wr_line;
        if (start)
            rd_line_reg <= mem[RI_W'(row_full)];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            clr_reg   <= '0;
            row_reg   <= '0;
            tag_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_CLR:
                begin
                    clr_reg <= clr_reg + RI_W'(1);
                    if (clr_reg == RI_W'(NROWS - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (start)
                    begin
                        row_reg   <= RI_W'(row_full);
                        tag_reg   <= TAG_W'(tag_full);
                        state_reg <= S_RD;
                    end
                end
                S_RD: state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// ----- src/tllc_back.sv -----
// request execution: sequences the two levels and holds the result register
module tllc_back #(
    parameter int LOG2_MAX_ROWS = tllc_pkg::LOG2_MAX_ROWS_DEF,
    parameter int MAX_WAYS      = tllc_pkg::MAX_WAYS_DEF,
    parameter int ADDR_BITS     = tllc_pkg::ADDR_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  tllc_pkg::lvl_cfg_t         l1_cfg,
    input  tllc_pkg::lvl_cfg_t         l2_cfg,
    input  logic                       job_valid,
    output logic                       job_ready,
    input  tllc_pkg::job_t             job,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       cache_level,
    output logic [1:0]                 event_res,
    output logic [tllc_pkg::PC_W-1:0]  pc_out,
    output logic [ADDR_BITS-1:0]       addr_out,
    output logic [tllc_pkg::ROW_W-1:0] row_index,
    output logic                       last
);
    import tllc_pkg::*;

    localparam logic [2:0] B_IDLE = 3'd0;
    localparam logic [2:0] B_L1   = 3'd1;
    localparam logic [2:0] B_O1   = 3'd2;
    localparam logic [2:0] B_L2   = 3'd3;
    localparam logic [2:0] B_O2   = 3'd4;

    logic [2:0] state_reg;
    job_t       job_reg;
    logic       l1_busy, l2_busy, l1_done, l2_done, l1_hit, l2_hit;
    logic       l1_start, l2_start;
    logic [ROW_W-1:0] l1_row, l2_row;
    logic       ov_reg, lvl_reg, last_reg;
    logic [1:0] ev_reg;
    logic [ROW_W-1:0] row_reg;
    logic       go_l2;

    // a level result lands in the cycle after its start, so the result register
    // has to be empty or leaving when a level is started
    assign job_ready = (state_reg == B_IDLE) && !l1_busy && !l2_busy && (!ov_reg || out_ready);
    assign l1_start  = job_valid && job_ready;
    assign l2_start  = (state_reg == B_O1) && go_l2 && (!ov_reg || out_ready);

    tllc_level #(.LOG2_MAX_ROWS(LOG2_MAX_ROWS), .MAX_WAYS(MAX_WAYS)) u_l1 (
        .clk(clk), .rst_n(rst_n), .busy(l1_busy), .cfg(l1_cfg),
        .start(l1_start), .addr(job.addr), .done(l1_done), .hit(l1_hit),
        .row_out(l1_row)
    );

    tllc_level #(.LOG2_MAX_ROWS(LOG2_MAX_ROWS), .MAX_WAYS(MAX_WAYS)) u_l2 (
        .clk(clk), .rst_n(rst_n), .busy(l2_busy), .cfg(l2_cfg),
        .start(l2_start), .addr(job_reg.addr), .done(l2_done), .hit(l2_hit),
        .row_out(l2_row)
    );

    logic hit1_reg;
    assign go_l2 = job_reg.l2_en && (job_reg.store || !hit1_reg);

    assign out_valid   = ov_reg;
    assign cache_level = lvl_reg;
    assign event_res   = ev_reg;
    assign pc_out      = job_reg.pc;
    assign addr_out    = job_reg.addr[ADDR_BITS-1:0];
    assign row_index   = row_reg;
    assign last        = last_reg;

    always_ff @(posedge clk)
    begin
        if (l1_start)
            job_reg <= job;
        if (l1_done)
        begin
            lvl_reg  <= 1'b0;
            hit1_reg <= l1_hit;
            ev_reg   <= job_reg.store ? EV_STORE : (l1_hit ? EV_HIT : EV_MISS);
            row_reg  <= l1_row;
            last_reg <= !(job_reg.l2_en && (job_reg.store || !l1_hit));
        end
        else if (l2_done)
        begin
            lvl_reg  <= 1'b1;
            ev_reg   <= job_reg.store ? EV_STORE : (l2_hit ? EV_HIT : EV_MISS);
            row_reg  <= l2_row;
            last_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                B_IDLE: if (l1_start) state_reg <= B_L1;
                B_L1:
                begin
                    // result register must be free before it is overwritten
                    if (!ov_reg || out_ready)
                    begin
                        state_reg <= B_O1;
                    end
                end
                B_O1:
                begin
                    if (go_l2)
                    begin
                        if (l2_start) state_reg <= B_L2;
                    end
                    else
                        state_reg <= B_IDLE;
                end
                B_L2: state_reg <= B_O2;
                B_O2: state_reg <= B_IDLE;
                default: state_reg <= B_IDLE;
            endcase
            if (l1_done || l2_done)
                ov_reg <= 1'b1;
            else if (ov_reg && out_ready)
                ov_reg <= 1'b0;
        end
    end

endmodule

// ----- src/two_level_lru_cache_tags.sv -----
// top level of the two-level lru cache tag model
//
//  channel   signals                                   direction
//  request   valid/ready, req_type, addr, pc           in
//  result    out_valid/out_ready, cache_level .. last  out
//  config    cfg_valid/cfg_ready, cfg_index, cfg_data  in
//
// for a request that stays in l1 the back end reads the row, updates it and hands the
// result; one that also visits l2 then reads, updates and hands a result in l2 as well
// after reset each level sweeps its row memory before the back end starts the first
// request; config writes are taken throughout
// a two-entry queue parts intake from execution; a level only starts when the result
// register is empty or being taken, so a stalled result holds the back end
module two_level_lru_cache_tags #(
    parameter int LOG2_MAX_ROWS = tllc_pkg::LOG2_MAX_ROWS_DEF,
    parameter int MAX_WAYS      = tllc_pkg::MAX_WAYS_DEF,
    parameter int ADDR_BITS     = tllc_pkg::ADDR_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           valid,
    output logic                           ready,
    input  logic                           req_type,
    input  logic [ADDR_BITS-1:0]           addr,
    input  logic [tllc_pkg::PC_W-1:0]      pc,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           cache_level,
    output logic [1:0]                     event_res,
    output logic [tllc_pkg::PC_W-1:0]      pc_out,
    output logic [ADDR_BITS-1:0]           addr_out,
    output logic [tllc_pkg::ROW_W-1:0]     row_index,
    output logic                           last,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [tllc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tllc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import tllc_pkg::*;

    lvl_cfg_t l1_cfg, l2_cfg;
    job_t     job;
    logic     job_valid, job_ready;

    tllc_front #(.ADDR_BITS(ADDR_BITS)) u_front (
        .clk(clk), .rst_n(rst_n), .valid(valid), .ready(ready),
        .req_type(req_type), .addr(addr), .pc(pc),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .l1_cfg(l1_cfg), .l2_cfg(l2_cfg),
        .job_valid(job_valid), .job_ready(job_ready), .job(job)
    );

    tllc_back #(.LOG2_MAX_ROWS(LOG2_MAX_ROWS), .MAX_WAYS(MAX_WAYS),
                .ADDR_BITS(ADDR_BITS)) u_back (
        .clk(clk), .rst_n(rst_n), .l1_cfg(l1_cfg), .l2_cfg(l2_cfg),
        .job_valid(job_valid), .job_ready(job_ready), .job(job),
        .out_valid(out_valid), .out_ready(out_ready), .cache_level(cache_level),
        .event_res(event_res), .pc_out(pc_out), .addr_out(addr_out),
        .row_index(row_index), .last(last)
    );

    // an l2 result is always the last of its request
    a_l2_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && cache_level |-> last)
        else $error("l2 result not marked last");

    // the event code of a result is always store, hit or miss
    a_ev_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (event_res == EV_STORE || event_res == EV_HIT || event_res == EV_MISS))
        else $error("bad event code");

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(row_index) && $stable(last))
        else $error("result changed while stalled");

endmodule
